// File: design/pmsfp_pkg.sv
// Shared types and constants of the particle sensor frame parser.
package pmsfp_pkg;

  localparam int unsigned CodeW = 3;
  localparam int unsigned PmW   = 16;
  localparam int unsigned CoefW = 8;

  // Response codes
  localparam logic [CodeW-1:0] RC_UNKNOWN = 3'd0;
  localparam logic [CodeW-1:0] RC_ACK     = 3'd1;
  localparam logic [CodeW-1:0] RC_NAK     = 3'd2;
  localparam logic [CodeW-1:0] RC_SINGLE  = 3'd3;
  localparam logic [CodeW-1:0] RC_AUTO    = 3'd4;
  localparam logic [CodeW-1:0] RC_COEFF   = 3'd5;
  localparam logic [CodeW-1:0] RC_AZERO   = 3'd6;
  localparam logic [CodeW-1:0] RC_TIMEOUT = 3'd7;

  // Reset values of the stored readings
  localparam logic [PmW-1:0]   PM_RESET    = 16'hFFFF;
  localparam logic [CoefW-1:0] COEFF_RESET = 8'd100;

  // One response beat
  typedef struct packed {
    logic             valid;
    logic [CodeW-1:0] code;
    logic [PmW-1:0]   fine;
    logic [PmW-1:0]   coarse;
    logic [CoefW-1:0] coeff;
  } resp_t;

endpackage

// File: design/pm_sensor_frame_parser.sv
// Top level of the particle sensor frame parser: stream ports and output skid register.
//
// Takes one sensor UART byte or receive-timeout event per beat and accepts a beat
// every cycle while the slave side is ready. Each beat is parsed in the same cycle
// it is accepted; a frame that completes on that beat, or a timeout, registers one
// response beat for the master side, carrying the response code and the stored
// PM2.5, PM10 and coefficient readings after that frame. Responses pass through
// an output register and a one-entry skid register, so the slave side stays ready
// while one response waits; it stalls only when both hold a response. Frame lengths
// above MAX_FRAME_LEN are reported as unknown and hunting resumes.
module pm_sensor_frame_parser #(
  parameter int unsigned MAX_FRAME_LEN = 36
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [15:0] pm_fine, [31:16] pm_coarse, [39:32] coeff_value
  output logic [2:0]  m_axis_tuser_o    // [2:0] response_code
);
  import pmsfp_pkg::*;

  resp_t resp;
  resp_t out_q, skid_q;
  logic  out_valid_q, skid_valid_q;
  logic  in_fire;

  assign s_axis_tready_o = !skid_valid_q;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  pmsfp_core #(
    .MAX_FRAME_LEN(MAX_FRAME_LEN)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (in_fire),
    .func_i     (s_axis_tuser_i),
    .data_byte_i(s_axis_tdata_i),
    .resp_o     (resp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready_i) begin
      // drain the skid entry first, otherwise take the new response
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= resp.valid;
      end
    end else if (resp.valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready_i) begin
      out_q <= skid_valid_q ? skid_q : resp;
    end else if (resp.valid) begin
      skid_q <= resp;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.code;
  assign m_axis_tdata_o  = {out_q.coeff, out_q.coarse, out_q.fine};

endmodule

// File: design/pmsfp_core.sv
// Frame parsing state machine: hunts headers, sums, captures and stores readings.
module pmsfp_core #(
  parameter int unsigned MAX_FRAME_LEN = 36
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic              func_i,
  input  logic [7:0]        data_byte_i,
  output pmsfp_pkg::resp_t  resp_o
);
  import pmsfp_pkg::*;

  localparam logic [7:0] LenMax = 8'(MAX_FRAME_LEN);

  localparam logic [7:0] HDR_ACK   = 8'hA5;
  localparam logic [7:0] HDR_NAK   = 8'h96;
  localparam logic [7:0] HDR_SHORT = 8'h40;
  localparam logic [7:0] HDR_AUTO  = 8'h42;
  localparam logic [7:0] HDR_AUTO2 = 8'h4D;
  localparam logic [7:0] CMD_PM    = 8'h04;
  localparam logic [7:0] CMD_COEFF = 8'h10;
  localparam logic [7:0] SHORT_FIRST = 8'd3;
  localparam logic [7:0] AUTO_FIRST  = 8'd6;

  typedef enum logic [5:0] {
    PH_HUNT   = 6'b000001,
    PH_SECOND = 6'b000010,
    PH_SHORT  = 6'b000100,
    PH_LENHI  = 6'b001000,
    PH_LENLO  = 6'b010000,
    PH_AUTO   = 6'b100000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_NAK   = 2'd1,
    KIND_SHORT = 2'd2,
    KIND_AUTO  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [15:0] fine;
    logic [15:0] coarse;
  } pend_t;

  function automatic pend_t capture(logic [7:0] pos, logic [7:0] b, logic [7:0] first,
                                    pend_t cur);
    pend_t r;
    r = cur;
    if (pos == first) begin
      r.fine[15:8] = b;
    end else if (pos == first + 8'd1) begin
      r.fine[7:0] = b;
    end else if (pos == first + 8'd2) begin
      r.coarse[15:8] = b;
    end else if (pos == first + 8'd3) begin
      r.coarse[7:0] = b;
    end
    return r;
  endfunction

  phase_e      phase_q, phase_d;
  kind_e       kind_q, kind_d;
  logic [7:0]  len_q, len_d;      // length high byte while in PH_LENLO
  logic [7:0]  pos_q, pos_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  sumhi_q, sumhi_d;
  pend_t       pend_q, pend_d;
  logic [15:0] fine_q, fine_d;
  logic [15:0] coarse_q, coarse_d;
  logic [7:0]  coeff_q, coeff_d;

  logic        emit;
  logic [2:0]  code;
  pend_t       pend_n;
  logic [7:0]  cmd_n;
  logic [8:0]  pos9, len9;
  logic [15:0] sum_add;

  assign pos9    = {1'b0, pos_q};
  assign len9    = {1'b0, len_q};
  assign sum_add = sum_q + {8'd0, data_byte_i};

  always_comb begin
    phase_d  = phase_q;
    kind_d   = kind_q;
    len_d    = len_q;
    pos_d    = pos_q;
    sum_d    = sum_q;
    cmd_d    = cmd_q;
    sumhi_d  = sumhi_q;
    pend_d   = pend_q;
    fine_d   = fine_q;
    coarse_d = coarse_q;
    coeff_d  = coeff_q;
    emit     = 1'b0;
    code     = RC_UNKNOWN;
    cmd_n    = (pos_q == 8'd2) ? data_byte_i : cmd_q;
    pend_n   = capture(pos_q, data_byte_i,
                       (phase_q == PH_AUTO) ? AUTO_FIRST : SHORT_FIRST, pend_q);

    if (fire_i) begin
      if (func_i) begin
        emit    = 1'b1;
        code    = RC_TIMEOUT;
        phase_d = PH_HUNT;
      end else begin
        unique case (phase_q)
          PH_HUNT: begin
            if (data_byte_i == HDR_ACK || data_byte_i == HDR_NAK ||
                data_byte_i == HDR_SHORT || data_byte_i == HDR_AUTO) begin
              priority if (data_byte_i == HDR_ACK)   kind_d = KIND_ACK;
              else if (data_byte_i == HDR_NAK)       kind_d = KIND_NAK;
              else if (data_byte_i == HDR_SHORT)     kind_d = KIND_SHORT;
              else                                   kind_d = KIND_AUTO;
              sum_d   = {8'd0, data_byte_i};
              pos_d   = 8'd1;
              len_d   = 8'd0;
              cmd_d   = 8'd0;
              sumhi_d = 8'd0;
              pend_d  = '0;
              phase_d = PH_SECOND;
            end
          end
          PH_SECOND: begin
            unique case (kind_q)
              KIND_ACK: begin
                emit = 1'b1;
                code = (data_byte_i == HDR_ACK) ? RC_ACK : RC_UNKNOWN;
                phase_d = PH_HUNT;
              end
              KIND_NAK: begin
                emit = 1'b1;
                code = (data_byte_i == HDR_NAK) ? RC_NAK : RC_UNKNOWN;
                phase_d = PH_HUNT;
              end
              KIND_SHORT: begin
                if (data_byte_i > LenMax) begin
                  emit    = 1'b1;
                  phase_d = PH_HUNT;
                end else begin
                  len_d   = data_byte_i;
                  sum_d   = sum_add;
                  pos_d   = 8'd2;
                  phase_d = PH_SHORT;
                end
              end
              default: begin
                if (data_byte_i != HDR_AUTO2) begin
                  emit    = 1'b1;
                  phase_d = PH_HUNT;
                end else begin
                  sum_d   = sum_add;
                  pos_d   = 8'd2;
                  phase_d = PH_LENHI;
                end
              end
            endcase
          end
          PH_SHORT: begin
            cmd_d  = cmd_n;
            pend_d = pend_n;
            if (pos9 <= len9 + 9'd1) begin
              sum_d = sum_add;
              pos_d = pos_q + 8'd1;
            end else begin
              emit    = 1'b1;
              phase_d = PH_HUNT;
              // checksum is the two's complement of the low sum byte
              if ((8'd0 - sum_q[7:0]) != data_byte_i) begin
                code = RC_UNKNOWN;
              end else if (cmd_n == CMD_PM) begin
                fine_d   = pend_n.fine;
                coarse_d = pend_n.coarse;
                code     = RC_SINGLE;
              end else if (cmd_n == CMD_COEFF) begin
                coeff_d = pend_n.fine[15:8];
                code    = RC_COEFF;
              end else begin
                code = RC_UNKNOWN;
              end
            end
          end
          PH_LENHI: begin
            len_d   = data_byte_i;
            sum_d   = sum_add;
            pos_d   = 8'd3;
            phase_d = PH_LENLO;
          end
          PH_LENLO: begin
            sum_d = sum_add;
            if (len_q != 8'd0 || data_byte_i > LenMax || data_byte_i == 8'd0) begin
              emit    = 1'b1;
              phase_d = PH_HUNT;
            end else begin
              len_d   = data_byte_i;
              pos_d   = 8'd4;
              phase_d = PH_AUTO;
            end
          end
          PH_AUTO: begin
            pend_d = pend_n;
            if (pos9 < len9 + 9'd3) begin
              if (pos9 <= len9 + 9'd1) begin
                sum_d = sum_add;
              end else begin
                sumhi_d = data_byte_i;
              end
              pos_d = pos_q + 8'd1;
            end else begin
              emit    = 1'b1;
              phase_d = PH_HUNT;
              if (len_q < 8'd2 || {sumhi_q, data_byte_i} != sum_q) begin
                code = RC_UNKNOWN;
              end else if (pend_n.fine == 16'd0 && pend_n.coarse == 16'd0) begin
                code = RC_AZERO;
              end else begin
                fine_d   = pend_n.fine;
                coarse_d = pend_n.coarse;
                code     = RC_AUTO;
              end
            end
          end
          default: begin
            phase_d = PH_HUNT;
          end
        endcase
      end
    end
  end

  always_comb begin
    resp_o.valid  = emit;
    resp_o.code   = code;
    resp_o.fine   = fine_d;
    resp_o.coarse = coarse_d;
    resp_o.coeff  = coeff_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      kind_q   <= KIND_ACK;
      len_q    <= '0;
      pos_q    <= '0;
      sum_q    <= '0;
      cmd_q    <= '0;
      sumhi_q  <= '0;
      pend_q   <= '0;
      fine_q   <= PM_RESET;
      coarse_q <= PM_RESET;
      coeff_q  <= COEFF_RESET;
    end else begin
      phase_q  <= phase_d;
      kind_q   <= kind_d;
      len_q    <= len_d;
      pos_q    <= pos_d;
      sum_q    <= sum_d;
      cmd_q    <= cmd_d;
      sumhi_q  <= sumhi_d;
      pend_q   <= pend_d;
      fine_q   <= fine_d;
      coarse_q <= coarse_d;
      coeff_q  <= coeff_d;
    end
  end

endmodule

// File: bench/pmsfp_checker.sv
// Frame constants of the bench and the response checker of the particle sensor frame parser.
`timescale 1ns / 1ps

package pmsfp_bench_pkg;

  localparam int unsigned MaxFrameLen = 36;

  localparam logic [7:0] HDR_ACK      = 8'hA5;
  localparam logic [7:0] HDR_NAK      = 8'h96;
  localparam logic [7:0] HDR_SHORT    = 8'h40;
  localparam logic [7:0] HDR_AUTO     = 8'h42;
  localparam logic [7:0] HDR_AUTO_2ND = 8'h4D;
  localparam logic [7:0] CMD_READ_PM  = 8'h04;
  localparam logic [7:0] CMD_COEFF    = 8'h10;

endpackage

module pmsfp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] func
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [39:0] m_axis_tdata_i,   // [15:0] pm_fine, [31:16] pm_coarse, [39:32] coeff_value
  input  logic [2:0]  m_axis_tuser_i,   // [2:0] response_code
  output int          fail_count_o,
  output int          pending_o
);
  import pmsfp_pkg::*;
  import pmsfp_bench_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT, PH_SECOND, PH_SHORT, PH_LENHI, PH_LENLO, PH_AUTO
  } phase_e;

  typedef enum logic [1:0] {FK_ACK, FK_NAK, FK_SHORT, FK_AUTO} kind_e;

  phase_e         phase;
  kind_e          kind;
  logic [15:0]    frame_len;
  logic [7:0]     byte_pos;
  logic [15:0]    run_sum;
  logic [7:0]     cmd_byte;
  logic [7:0]     sum_hi;
  logic [15:0]    fine_pend;
  logic [15:0]    coarse_pend;
  logic [15:0]    fine_keep;
  logic [15:0]    coarse_keep;
  logic [7:0]     coeff_keep;
  resp_t          want_q [$];

  initial fail_count_o = 0;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: %s mismatch, got %0h, want %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  // Close the frame: back to hunting, queue the response with the stored readings.
  task automatic post_resp(input logic [CodeW-1:0] code);
    resp_t r;
    phase    = PH_HUNT;
    r.valid  = 1'b1;
    r.code   = code;
    r.fine   = fine_keep;
    r.coarse = coarse_keep;
    r.coeff  = coeff_keep;
    want_q.push_back(r);
  endtask

  task automatic capture(input int unsigned pos, input logic [7:0] b,
                         input int unsigned first);
    if (pos == first) begin
      fine_pend[15:8] = b;
    end else if (pos == first + 1) begin
      fine_pend[7:0] = b;
    end else if (pos == first + 2) begin
      coarse_pend[15:8] = b;
    end else if (pos == first + 3) begin
      coarse_pend[7:0] = b;
    end
  endtask

  task automatic parse_beat(input logic is_tmo, input logic [7:0] b);
    int unsigned pos;
    int unsigned len;
    logic [7:0]  neg_sum;
    pos = byte_pos;
    len = frame_len;
    if (is_tmo) begin
      post_resp(RC_TIMEOUT);
    end else begin
      case (phase)
        PH_HUNT: begin
          if (b == HDR_ACK || b == HDR_NAK || b == HDR_SHORT || b == HDR_AUTO) begin
            if (b == HDR_ACK) kind = FK_ACK;
            else if (b == HDR_NAK) kind = FK_NAK;
            else if (b == HDR_SHORT) kind = FK_SHORT;
            else kind = FK_AUTO;
            run_sum     = {8'h00, b};
            byte_pos    = 8'd1;
            frame_len   = '0;
            cmd_byte    = '0;
            sum_hi      = '0;
            fine_pend   = '0;
            coarse_pend = '0;
            phase       = PH_SECOND;
          end
        end
        PH_SECOND: begin
          case (kind)
            FK_ACK: post_resp((b == HDR_ACK) ? RC_ACK : RC_UNKNOWN);
            FK_NAK: post_resp((b == HDR_NAK) ? RC_NAK : RC_UNKNOWN);
            FK_SHORT: begin
              if (b > MaxFrameLen) begin
                post_resp(RC_UNKNOWN);
              end else begin
                frame_len = {8'h00, b};
                run_sum   = run_sum + 16'(b);
                byte_pos  = 8'd2;
                phase     = PH_SHORT;
              end
            end
            default: begin
              if (b != HDR_AUTO_2ND) begin
                post_resp(RC_UNKNOWN);
              end else begin
                run_sum  = run_sum + 16'(b);
                byte_pos = 8'd2;
                phase    = PH_LENHI;
              end
            end
          endcase
        end
        PH_SHORT: begin
          if (pos == 2) cmd_byte = b;
          capture(pos, b, 3);
          neg_sum = 8'd0 - run_sum[7:0];
          if (pos <= len + 1) begin
            run_sum  = run_sum + 16'(b);
            byte_pos = byte_pos + 8'd1;
          end else if (neg_sum != b) begin
            post_resp(RC_UNKNOWN);
          end else if (cmd_byte == CMD_READ_PM) begin
            fine_keep   = fine_pend;
            coarse_keep = coarse_pend;
            post_resp(RC_SINGLE);
          end else if (cmd_byte == CMD_COEFF) begin
            coeff_keep = fine_pend[15:8];
            post_resp(RC_COEFF);
          end else begin
            post_resp(RC_UNKNOWN);
          end
        end
        PH_LENHI: begin
          frame_len = {b, 8'h00};
          run_sum   = run_sum + 16'(b);
          byte_pos  = 8'd3;
          phase     = PH_LENLO;
        end
        PH_LENLO: begin
          frame_len = frame_len | 16'(b);
          run_sum   = run_sum + 16'(b);
          if (frame_len > MaxFrameLen || frame_len == 16'd0) begin
            post_resp(RC_UNKNOWN);
          end else begin
            byte_pos = 8'd4;
            phase    = PH_AUTO;
          end
        end
        PH_AUTO: begin
          capture(pos, b, 6);
          if (pos < len + 3) begin
            if (pos <= len + 1) run_sum = run_sum + 16'(b);
            else sum_hi = b;
            byte_pos = byte_pos + 8'd1;
          end else if (len < 2) begin
            post_resp(RC_UNKNOWN);
          end else if ({sum_hi, b} != run_sum) begin
            post_resp(RC_UNKNOWN);
          end else if (fine_pend == 16'd0 && coarse_pend == 16'd0) begin
            post_resp(RC_AZERO);
          end else begin
            fine_keep   = fine_pend;
            coarse_keep = coarse_pend;
            post_resp(RC_AUTO);
          end
        end
        default: phase = PH_HUNT;
      endcase
    end
  endtask

  task automatic check_resp(input logic [2:0] code, input logic [15:0] fine,
                            input logic [15:0] coarse, input logic [7:0] coeff);
    resp_t w;
    if (want_q.size() == 0) begin
      report_mismatch("response with none expected, code", code, 0);
    end else begin
      w = want_q.pop_front();
      if (code !== w.code) report_mismatch("response_code", code, w.code);
      if (fine !== w.fine) report_mismatch("pm_fine", fine, w.fine);
      if (coarse !== w.coarse) report_mismatch("pm_coarse", coarse, w.coarse);
      if (coeff !== w.coeff) report_mismatch("coeff_value", coeff, w.coeff);
    end
  endtask

  // Retire the output beat first: it always belongs to an older input beat.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase       = PH_HUNT;
      kind        = FK_ACK;
      frame_len   = '0;
      byte_pos    = '0;
      run_sum     = '0;
      cmd_byte    = '0;
      sum_hi      = '0;
      fine_pend   = '0;
      coarse_pend = '0;
      fine_keep   = PM_RESET;
      coarse_keep = PM_RESET;
      coeff_keep  = COEFF_RESET;
      want_q.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        check_resp(m_axis_tuser_i, m_axis_tdata_i[15:0], m_axis_tdata_i[31:16],
                   m_axis_tdata_i[39:32]);
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        parse_beat(s_axis_tuser_i, s_axis_tdata_i);
      end
    end
    pending_o = want_q.size();
  end

endmodule

// File: bench/tb.sv
// Stimulus and verdict of the particle sensor frame parser bench.
`timescale 1ns / 1ps

module tb;
  import pmsfp_bench_pkg::*;

  localparam int unsigned RandItems   = 900;
  localparam int unsigned RxHoldCyc   = 300;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned LimitNs     = 5_000_000;

  typedef struct {
    logic       tmo;
    logic [7:0] b;
  } beat_t;

  logic        clk     = 1'b0;
  logic        rst_n   = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data  = 8'h00;
  logic        s_user  = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [39:0] m_data;
  logic [2:0]  m_user;
  int          fail_count;
  int          pending;

  beat_t       beat_q [$];
  bit          idle_on = 1'b1;
  int          hold_reqs = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pm_sensor_frame_parser #(
    .MAX_FRAME_LEN (MaxFrameLen)
  ) u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  pmsfp_checker u_chk (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .m_axis_tuser_i  (m_user),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  task automatic add_byte(input logic [7:0] b);
    beat_t bt;
    bt.tmo = 1'b0;
    bt.b   = b;
    beat_q.push_back(bt);
  endtask

  task automatic add_tmo();
    beat_t bt;
    bt.tmo = 1'b1;
    bt.b   = 8'($urandom);
    beat_q.push_back(bt);
  endtask

  function automatic logic [15:0] rand_reading();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 500));
      default: return 16'($urandom);
    endcase
  endfunction

  // 40 len cmd data.. chk; the readings sit right after the command byte.
  task automatic add_short(input logic [7:0] cmd, input logic [7:0] len,
                           input logic [15:0] fine, input logic [15:0] coarse, input bit bad);
    logic [7:0] sum;
    logic [7:0] b;
    sum = HDR_SHORT + len;
    add_byte(HDR_SHORT);
    add_byte(len);
    if (len <= MaxFrameLen) begin
      for (int i = 0; i < len; i++) begin
        case (i)
          0: b = cmd;
          1: b = fine[15:8];
          2: b = fine[7:0];
          3: b = coarse[15:8];
          4: b = coarse[7:0];
          default: b = 8'($urandom);
        endcase
        add_byte(b);
        sum = sum + b;
      end
      b = 8'd0 - sum;
      if (bad) b = b ^ 8'($urandom_range(1, 255));
      add_byte(b);
    end
  endtask

  // 42 4D lenH lenL data.. sumH sumL; the readings sit at positions 6 to 9.
  task automatic add_auto(input logic [15:0] len, input logic [15:0] fine,
                          input logic [15:0] coarse, input bit bad);
    logic [15:0] sum;
    logic [7:0]  b;
    sum = 16'(HDR_AUTO) + 16'(HDR_AUTO_2ND) + 16'(len[15:8]) + 16'(len[7:0]);
    add_byte(HDR_AUTO);
    add_byte(HDR_AUTO_2ND);
    add_byte(len[15:8]);
    add_byte(len[7:0]);
    if (len == 16'd1) begin
      add_byte(8'($urandom));
    end else if (len >= 16'd2 && len <= MaxFrameLen) begin
      for (int p = 4; p <= len + 1; p++) begin
        case (p)
          6: b = fine[15:8];
          7: b = fine[7:0];
          8: b = coarse[15:8];
          9: b = coarse[7:0];
          default: b = 8'($urandom);
        endcase
        add_byte(b);
        sum = sum + 16'(b);
      end
      if (bad) begin
        if ($urandom_range(0, 1)) sum[15:8] = sum[15:8] ^ 8'($urandom_range(1, 255));
        else sum[7:0] = sum[7:0] ^ 8'($urandom_range(1, 255));
      end
      add_byte(sum[15:8]);
      add_byte(sum[7:0]);
    end
  endtask

  // Hold the beat until accepted, then idle at random.
  task automatic drive_beat(input beat_t bt);
    int gap;
    s_valid <= 1'b1;
    s_data  <= bt.b;
    s_user  <= bt.tmo;
    do @(posedge clk); while (!s_ready);
    gap = 0;
    while (idle_on && $urandom_range(0, 99) < 11) gap++;
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_beats();
    beat_t bt;
    while (beat_q.size() != 0) begin
      bt = beat_q.pop_front();
      drive_beat(bt);
    end
  endtask

  task automatic wait_all_resp();
    s_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Receiver: random stalls, and a long hold-off whenever one is requested.
  initial begin
    int hold_served;
    hold_served = 0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_reqs) begin
        hold_served++;
        m_ready <= 1'b0;
        repeat (RxHoldCyc) @(posedge clk);
      end
      m_ready <= !idle_on || ($urandom_range(0, 99) >= 11);
    end
  end

  initial begin
    #(LimitNs);
    $display("[pm_sensor_frame_parser] ERROR");
    $finish;
  end

  initial begin
    int unsigned sent;
    int          r;
    int          c;
    int          k;
    bit          noise;
    bit          held;
    bit          paused;
    logic [7:0]  cmd;
    logic [7:0]  len8;
    logic [15:0] len16;
    sent   = 0;
    held   = 1'b0;
    paused = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames
    add_tmo();
    add_byte(HDR_ACK); add_byte(HDR_ACK);
    add_byte(HDR_NAK); add_byte(HDR_NAK);
    add_byte(HDR_ACK); add_byte(8'h00);
    add_byte(HDR_NAK); add_byte(8'hFF);
    add_byte(HDR_AUTO); add_byte(8'h00);
    add_byte(8'h00); add_byte(8'hFF); add_byte(HDR_AUTO_2ND);
    add_short(CMD_READ_PM, 8'd5, 16'hFFFF, 16'hFFFF, 1'b0);
    add_short(CMD_READ_PM, 8'd5, 16'h0000, 16'h0000, 1'b0);
    add_short(CMD_COEFF, 8'd2, 16'hFF00, 16'h0000, 1'b0);
    add_short(CMD_COEFF, 8'd2, 16'h00FF, 16'h0000, 1'b0);
    add_short(8'h7F, 8'd3, 16'h1234, 16'h0000, 1'b0);
    add_short(CMD_READ_PM, 8'd0, 16'h0000, 16'h0000, 1'b0);
    add_short(CMD_READ_PM, 8'(MaxFrameLen), 16'h0102, 16'h0304, 1'b0);
    add_short(CMD_READ_PM, 8'(MaxFrameLen + 1), 16'h0000, 16'h0000, 1'b0);
    add_short(CMD_READ_PM, 8'hFF, 16'h0000, 16'h0000, 1'b0);
    add_short(CMD_READ_PM, 8'd5, 16'h5555, 16'hAAAA, 1'b1);
    add_short(CMD_READ_PM, 8'd4, 16'h0A0B, 16'h0C00, 1'b0);
    add_auto(16'd28, 16'h00C8, 16'h01F4, 1'b0);
    add_auto(16'd28, 16'h0000, 16'h0000, 1'b0);
    add_auto(16'd0, 16'h0000, 16'h0000, 1'b0);
    add_auto(16'd1, 16'h0000, 16'h0000, 1'b0);
    add_auto(16'(MaxFrameLen), 16'hFFFF, 16'h8001, 1'b0);
    add_auto(16'(MaxFrameLen + 1), 16'h0000, 16'h0000, 1'b0);
    add_auto(16'h8000, 16'h0000, 16'h0000, 1'b0);
    add_auto(16'd20, 16'h1111, 16'h2222, 1'b1);
    add_byte(HDR_AUTO); add_byte(HDR_AUTO_2ND); add_byte(8'h00); add_tmo();
    sent = beat_q.size();
    drain_beats();

    while (sent < RandItems) begin
      noise = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 10) begin
        add_byte(8'($urandom));
        noise = 1'b1;
      end else if (r < 15) begin
        add_tmo();
      end else if (r < 23) begin
        if ($urandom_range(0, 1)) begin
          add_byte(HDR_ACK); add_byte(HDR_ACK);
        end else begin
          add_byte(HDR_NAK); add_byte(HDR_NAK);
        end
      end else if (r < 27) begin
        add_byte($urandom_range(0, 1) ? HDR_ACK : HDR_NAK);
        add_byte(8'($urandom));
      end else if (r < 30) begin
        add_byte(HDR_AUTO);
        add_byte(8'($urandom));
      end else if (r < 60) begin
        c = $urandom_range(0, 99);
        cmd = (c < 45) ? CMD_READ_PM : (c < 80) ? CMD_COEFF : 8'($urandom);
        c = $urandom_range(0, 99);
        if (c < 80) len8 = (cmd == CMD_COEFF) ? 8'($urandom_range(2, 4)) : 8'($urandom_range(5, 8));
        else if (c < 95) len8 = 8'($urandom_range(0, MaxFrameLen));
        else len8 = 8'($urandom_range(MaxFrameLen + 1, 255));
        add_short(cmd, len8, rand_reading(), rand_reading(), $urandom_range(0, 9) == 0);
      end else if (r < 97) begin
        c = $urandom_range(0, 99);
        if (c < 70) len16 = 16'($urandom_range(6, 12));
        else len16 = 16'($urandom_range(2, MaxFrameLen));
        if ($urandom_range(0, 9) == 0) add_auto(len16, 16'h0000, 16'h0000, 1'b0);
        else add_auto(len16, rand_reading(), rand_reading(), $urandom_range(0, 9) == 0);
      end else begin
        case ($urandom_range(0, 3))
          0: len16 = 16'd0;
          1: len16 = 16'd1;
          2: len16 = 16'($urandom_range(MaxFrameLen + 1, 255));
          default: len16 = {8'($urandom_range(1, 255)), 8'($urandom)};
        endcase
        add_auto(len16, rand_reading(), rand_reading(), 1'b0);
      end
      // abandon the frame midway now and then
      if (!noise && beat_q.size() > 1 && $urandom_range(0, 99) < 5) begin
        k = $urandom_range(1, beat_q.size() - 1);
        while (beat_q.size() > k) beat_q.delete(beat_q.size() - 1);
        add_tmo();
      end
      sent += beat_q.size();
      drain_beats();

      if (!held && sent >= 250) begin
        held = 1'b1;
        hold_reqs++;
      end
      idle_on = !(sent >= 400 && sent < 600);
      if (!paused && sent >= 700) begin
        paused = 1'b1;
        wait_all_resp();
      end
    end

    wait_all_resp();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("[pm_sensor_frame_parser] OK");
    end else begin
      $display("[pm_sensor_frame_parser] ERROR");
    end
    $finish;
  end

endmodule
